FILE: src/pps_disciplined_time_mapper_defines.svh
// assertion macros for the time mapper rtl
`ifndef PPS_DISCIPLINED_TIME_MAPPER_DEFINES_SVH
`define PPS_DISCIPLINED_TIME_MAPPER_DEFINES_SVH

// checked property, masked while reset is asserted
`define PDTM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property that also holds during reset
`define PDTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pdtm_pkg.sv
// types and constants for the pps disciplined time mapper
`timescale 1ns / 1ps

package pdtm_pkg;

	localparam int TICK_W = 32;
	localparam int WMS_W  = 30;
	localparam int CMD_W  = 2;
	localparam int RATE_W = 16;

	localparam logic [CMD_W-1:0] CMD_PPS = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FWD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REV = 2'd2;

	localparam logic [WMS_W-1:0]  WEEK_MS       = 30'd604800000;
	localparam logic signed [WMS_W:0] WEEK_MS_S  = 31'sd604800000;
	localparam logic signed [WMS_W:0] HALF_WEEK_S = 31'sd302400000;
	localparam logic [RATE_W-1:0] NOMINAL_RESET = 16'd1000;

	// request to the serial multiply/divide unit
	typedef struct packed {
		logic              start;
		logic [TICK_W-1:0] mcand;
		logic [TICK_W-1:0] mplier;
		logic [TICK_W-1:0] divisor;
	} md_ctl_t;

	// status and result of the serial multiply/divide unit
	typedef struct packed {
		logic              idle;
		logic              done;
		logic [TICK_W-1:0] quot_lo;
		logic [WMS_W-1:0]  quot_mod;
	} md_sts_t;

endpackage

FILE: src/pdtm_intf.sv
// handshake channels for query items and result items
`timescale 1ns / 1ps

interface pdtm_in_if import pdtm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [TICK_W-1:0] tick_value;
	logic [WMS_W-1:0]  week_ms;

	modport source (output valid, output cmd, output tick_value, output week_ms, input ready);
	modport sink (input valid, input cmd, input tick_value, input week_ms, output ready);
endinterface

interface pdtm_out_if import pdtm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] converted_value;
	logic              disciplined;
	logic              measured_rate_used;

	modport source (output valid, output converted_value, output disciplined,
		output measured_rate_used, input ready);
	modport sink (input valid, input converted_value, input disciplined,
		input measured_rate_used, output ready);
endinterface

FILE: src/pdtm_muldiv.sv
// bit-serial unsigned multiply then restoring divide, quotient also reduced mod week
`timescale 1ns / 1ps

module pdtm_muldiv import pdtm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_ctl_t ctl,
	output md_sts_t sts
);

	localparam int MUL_STEPS = TICK_W;
	localparam int DIV_STEPS = 2 * TICK_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV, PH_DONE} phase_t;

	phase_t            phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TICK_W-1:0] mcand_q;
	logic [TICK_W-1:0] div_q;
	logic [TICK_W-1:0] hi_q;
	logic [TICK_W-1:0] lo_q;
	logic [TICK_W-1:0] rem_q;
	logic [WMS_W-1:0]  qmod_q;

	logic [TICK_W:0]   mul_sum;
	logic [TICK_W:0]   rem_shift;
	logic [TICK_W:0]   rem_diff;
	logic              qbit;
	logic [WMS_W:0]    mod_shift;
	logic [WMS_W-1:0]  mod_next;

	always_comb begin
		mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
		rem_shift = {rem_q, hi_q[TICK_W-1]};
		rem_diff  = rem_shift - {1'b0, div_q};
		qbit      = (rem_shift >= {1'b0, div_q});
		// running residue of the quotient prefix, msb first
		mod_shift = {qmod_q, qbit};
		mod_next  = (mod_shift >= {1'b0, WEEK_MS}) ? WMS_W'(mod_shift - {1'b0, WEEK_MS})
			: mod_shift[WMS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (ctl.start) begin
						mcand_q <= ctl.mcand;
						div_q   <= ctl.divisor;
						hi_q    <= '0;
						lo_q    <= ctl.mplier;
						cnt_q   <= '0;
						phase_q <= PH_MUL;
					end
				end
				PH_MUL: begin
					hi_q <= mul_sum[TICK_W:1];
					lo_q <= {mul_sum[0], lo_q[TICK_W-1:1]};
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						qmod_q  <= '0;
						phase_q <= PH_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DIV: begin
					// dividend shifts out of the top, quotient bits enter at the bottom
					rem_q  <= qbit ? rem_diff[TICK_W-1:0] : rem_shift[TICK_W-1:0];
					hi_q   <= {hi_q[TICK_W-2:0], lo_q[TICK_W-1]};
					lo_q   <= {lo_q[TICK_W-2:0], qbit};
					qmod_q <= mod_next;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						phase_q <= PH_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DONE: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	assign sts.idle     = (phase_q == PH_IDLE);
	assign sts.done     = (phase_q == PH_DONE);
	assign sts.quot_lo  = lo_q;
	assign sts.quot_mod = qmod_q;

endmodule

FILE: src/pps_disciplined_time_mapper.sv
// pps disciplined time mapper: observation store, query control and result register
// a pps item gives no result and leaves the input open for the next item
// a disciplined query gives its result once finish finds the result register free, the input reopens with it
// so no new item is taken while a query runs; the bit-serial multiply and divide dominate
// an undisciplined query skips the prep and run states and gives a zero result
// reset clears both valid bits, sets the nominal rate to 1000 and empties the result register
`timescale 1ns / 1ps
`include "pps_disciplined_time_mapper_defines.svh"

module pps_disciplined_time_mapper import pdtm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [RATE_W-1:0] cfg_wr_data,
	pdtm_in_if.sink           in_ch,
	pdtm_out_if.source        out_ch
);

	typedef enum logic [2:0] {ST_IDLE, ST_DIFF, ST_PREP, ST_RUN, ST_FINISH} state_t;

	// shortest signed distance a - b across the week boundary
	function automatic logic signed [WMS_W:0] week_diff(input logic [WMS_W-1:0] a,
		input logic [WMS_W-1:0] b);
		logic signed [WMS_W:0] d;
		d = $signed({1'b0, a}) - $signed({1'b0, b});
		if (d < -HALF_WEEK_S)
			d = d + WEEK_MS_S;
		else if (d > HALF_WEEK_S)
			d = d - WEEK_MS_S;
		return d;
	endfunction

	state_t                 state_q;
	logic [RATE_W-1:0]      nominal_q;

	logic [TICK_W-1:0]      newer_tick_q;
	logic [WMS_W-1:0]       newer_wms_q;
	logic                   newer_valid_q;
	logic [TICK_W-1:0]      older_tick_q;
	logic [WMS_W-1:0]       older_wms_q;
	logic                   older_valid_q;

	logic                   fwd_q;
	logic [TICK_W-1:0]      tick_q;
	logic [WMS_W-1:0]       wms_q;
	logic [TICK_W-1:0]      obs_ticks_q;
	logic signed [WMS_W:0]  obs_ms_q;
	logic [TICK_W-1:0]      delta_q;
	logic                   meas_q;
	logic                   neg_q;
	logic [WMS_W-1:0]       base_q;

	logic                   out_valid_q;
	logic [TICK_W-1:0]      out_value_q;
	logic                   out_disc_q;
	logic                   out_meas_q;

	md_ctl_t                md_ctl;
	md_sts_t                md_sts;

	logic                   meas_now;
	logic [TICK_W-1:0]      mag_delta;
	logic [TICK_W-1:0]      mag_obs_ms;
	logic [TICK_W-1:0]      rate;
	logic signed [WMS_W:0]  dm_now;
	logic [WMS_W:0]         fwd_sum;
	logic [WMS_W:0]         fwd_dif;
	logic [WMS_W-1:0]       fwd_value;
	logic [TICK_W-1:0]      rev_step;
	logic [TICK_W-1:0]      result_value;
	logic                   out_free;

	always_comb begin
		rate       = {{(TICK_W-RATE_W){1'b0}}, (nominal_q == '0) ? RATE_W'(1) : nominal_q};
		mag_delta  = delta_q[TICK_W-1] ? -delta_q : delta_q;
		mag_obs_ms = {1'b0, (obs_ms_q[WMS_W] ? WMS_W'(-obs_ms_q) : WMS_W'(obs_ms_q)),
			{(TICK_W-WMS_W-1){1'b0}}} >> (TICK_W - WMS_W - 1);
		// measured rate needs a positive tick span, and for reverse a nonzero week span
		meas_now   = older_valid_q && !obs_ticks_q[TICK_W-1] && (obs_ticks_q != '0)
			&& (fwd_q || (obs_ms_q != '0));
		dm_now     = week_diff(wms_q, newer_wms_q);

		md_ctl.start  = (state_q == ST_PREP);
		md_ctl.mcand  = mag_delta;
		if (fwd_q) begin
			md_ctl.mplier  = meas_now ? mag_obs_ms : TICK_W'(1);
			md_ctl.divisor = meas_now ? obs_ticks_q : rate;
		end else begin
			md_ctl.mplier  = meas_now ? obs_ticks_q : rate;
			md_ctl.divisor = meas_now ? mag_obs_ms : TICK_W'(1);
		end

		// forward: base plus or minus the quotient residue, folded back into the week
		fwd_sum   = {1'b0, base_q} + {1'b0, md_sts.quot_mod};
		fwd_dif   = {1'b0, base_q} - {1'b0, md_sts.quot_mod};
		if (neg_q)
			fwd_value = fwd_dif[WMS_W] ? WMS_W'(fwd_dif + {1'b0, WEEK_MS}) : fwd_dif[WMS_W-1:0];
		else
			fwd_value = (fwd_sum >= {1'b0, WEEK_MS}) ? WMS_W'(fwd_sum - {1'b0, WEEK_MS})
				: fwd_sum[WMS_W-1:0];
		rev_step  = neg_q ? -md_sts.quot_lo : md_sts.quot_lo;

		if (!newer_valid_q)
			result_value = '0;
		else if (fwd_q)
			result_value = {{(TICK_W-WMS_W){1'b0}}, fwd_value};
		else
			result_value = newer_tick_q + rev_step;

		out_free = !out_valid_q || out_ch.ready;
	end

	pdtm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.sts    (md_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= NOMINAL_RESET;
		end else if (cfg_wr_en) begin
			nominal_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			newer_tick_q  <= '0;
			newer_wms_q   <= '0;
			newer_valid_q <= 1'b0;
			older_tick_q  <= '0;
			older_wms_q   <= '0;
			older_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// the finish state owns the result register while it is loading
			if (out_ch.ready && state_q != ST_FINISH)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						unique case (in_ch.cmd) inside
							CMD_PPS: begin
								if (newer_valid_q) begin
									older_tick_q  <= newer_tick_q;
									older_wms_q   <= newer_wms_q;
									older_valid_q <= 1'b1;
								end
								newer_tick_q  <= in_ch.tick_value;
								newer_wms_q   <= in_ch.week_ms;
								newer_valid_q <= 1'b1;
							end
							CMD_FWD, CMD_REV: begin
								fwd_q   <= (in_ch.cmd == CMD_FWD);
								tick_q  <= in_ch.tick_value;
								wms_q   <= in_ch.week_ms;
								state_q <= ST_DIFF;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIFF: begin
					obs_ticks_q <= newer_tick_q - older_tick_q;
					obs_ms_q    <= week_diff(newer_wms_q, older_wms_q);
					delta_q     <= fwd_q ? (tick_q - newer_tick_q)
						: {{(TICK_W-WMS_W-1){dm_now[WMS_W]}}, dm_now};
					state_q     <= newer_valid_q ? ST_PREP : ST_FINISH;
				end
				ST_PREP: begin
					meas_q  <= meas_now;
					neg_q   <= delta_q[TICK_W-1] ^ (meas_now & obs_ms_q[WMS_W]);
					base_q  <= (newer_wms_q >= WEEK_MS) ? (newer_wms_q - WEEK_MS) : newer_wms_q;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (md_sts.done)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= result_value;
						out_disc_q  <= newer_valid_q;
						out_meas_q  <= newer_valid_q && meas_q;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign in_ch.ready               = (state_q == ST_IDLE);
	assign out_ch.valid              = out_valid_q;
	assign out_ch.converted_value    = out_value_q;
	assign out_ch.disciplined        = out_disc_q;
	assign out_ch.measured_rate_used = out_meas_q;

	`PDTM_ASSERT(a_query_closes_input, clk, arst_n,
		(in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_FWD || in_ch.cmd == CMD_REV))
		|=> !in_ch.ready, "query item taken but input stays open")
	`PDTM_ASSERT(a_pps_marks_valid, clk, arst_n,
		(in_ch.valid && in_ch.ready && in_ch.cmd == CMD_PPS) |=> newer_valid_q,
		"pps item taken but newer observation not valid")
	`PDTM_ASSERT(a_start_when_unit_idle, clk, arst_n, md_ctl.start |-> md_sts.idle,
		"multiply/divide started while busy")
	`PDTM_ASSERT(a_measured_needs_pair, clk, arst_n,
		(out_ch.valid && out_ch.measured_rate_used) |-> (older_valid_q && out_ch.disciplined),
		"measured rate reported without two observations")
	`PDTM_ASSERT_ALWAYS(a_reset_quiet, clk,
		!arst_n |-> (!out_ch.valid && !md_ctl.start), "activity during reset")

endmodule
